// ===== hdl/r2bf_pkg.sv =====
// ----------------------------------------------------------------------------
// r2bf_pkg
// Shared constants and helpers for the scaled radix-2 butterfly.
// ----------------------------------------------------------------------------
package r2bf_pkg;

  // Register stages from an accepted beat to its result strobe.
  localparam int unsigned LATENCY = 4;

  // Round-half-to-even decision from the kept LSB, the half bit and the
  // OR of every bit below the half bit.
  function automatic logic round_up(logic lsb, logic half, logic sticky);
    return half & (lsb | sticky);
  endfunction

endpackage

// ===== hdl/r2bf_round.sv =====
// ----------------------------------------------------------------------------
// r2bf_round
// Scales a double-width value down by 2^DATA_WIDTH with round half to even
// and keeps the low DATA_WIDTH bits, so overflow wraps.
// ----------------------------------------------------------------------------
module r2bf_round #(
  parameter int unsigned DATA_WIDTH = 20
) (
  input  logic [2*DATA_WIDTH-1:0] value_i,
  output logic [DATA_WIDTH-1:0]   result_o
);

  logic [DATA_WIDTH-1:0] trunc;
  logic                  up;

  assign trunc = value_i[2*DATA_WIDTH-1:DATA_WIDTH];
  assign up    = r2bf_pkg::round_up(trunc[0], value_i[DATA_WIDTH-1],
                                    |value_i[DATA_WIDTH-2:0]);

  // The carry out of the top bit is dropped on purpose: results wrap.
  assign result_o = trunc + {{(DATA_WIDTH-1){1'b0}}, up};

endmodule

// ===== hdl/radix2_fft_butterfly.sv =====
// ----------------------------------------------------------------------------
// radix2_fft_butterfly
// The result of each accepted beat shows up with done_o high once it has passed
// the four register stages. Throughput: one beat per cycle, busy_o is always
// low and the four register stages never stall. Reset clears only the stage
// valid bits.
// ----------------------------------------------------------------------------
module radix2_fft_butterfly #(
  parameter int unsigned DATA_WIDTH = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [DATA_WIDTH-1:0] a_re_i,
  input  logic signed [DATA_WIDTH-1:0] a_im_i,
  input  logic signed [DATA_WIDTH-1:0] b_re_i,
  input  logic signed [DATA_WIDTH-1:0] b_im_i,
  input  logic signed [DATA_WIDTH-1:0] tw_re_i,
  input  logic signed [DATA_WIDTH-1:0] tw_im_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] sum_re_o,
  output logic signed [DATA_WIDTH-1:0] sum_im_o,
  output logic signed [DATA_WIDTH-1:0] diff_re_o,
  output logic signed [DATA_WIDTH-1:0] diff_im_o
);

  // Full-precision width. Everything that follows is taken modulo 2^PW:
  // the kept result bits never depend on anything above bit PW-1.
  localparam int unsigned PW = 2 * DATA_WIDTH;

  // The pipeline cannot be held off, so a beat is taken on every start_i.
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // Stage valid bits travel alongside the data.
  logic [r2bf_pkg::LATENCY-1:0] valid_d, valid_q;

  assign valid_d = {valid_q[r2bf_pkg::LATENCY-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage 1: the four partial products of B*W and A aligned to the product
  // scale (A shifted up by DATA_WIDTH-1 bits).
  logic signed [PW-1:0] p_rr_d, p_ii_d, p_ri_d, p_ir_d;
  logic [PW-1:0]        p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [PW-1:0]        a_re_al_d, a_im_al_d;
  logic [PW-1:0]        a_re_al_q, a_im_al_q;

  assign p_rr_d    = b_re_i * tw_re_i;
  assign p_ii_d    = b_im_i * tw_im_i;
  assign p_ri_d    = b_re_i * tw_im_i;
  assign p_ir_d    = b_im_i * tw_re_i;
  assign a_re_al_d = {a_re_i[DATA_WIDTH-1], a_re_i, {(DATA_WIDTH-1){1'b0}}};
  assign a_im_al_d = {a_im_i[DATA_WIDTH-1], a_im_i, {(DATA_WIDTH-1){1'b0}}};

  // Stage 2: the sum S = A*2^(N-1) + B*W. The aligned A is kept, shifted
  // once more, for the difference in the next stage.
  logic [PW-1:0] s_re_d, s_im_d, s_re_q, s_im_q;
  logic [PW-1:0] a2_re_d, a2_im_d, a2_re_q, a2_im_q;

  assign s_re_d  = a_re_al_q + p_rr_q - p_ii_q;
  assign s_im_d  = a_im_al_q + p_ri_q + p_ir_q;
  assign a2_re_d = {a_re_al_q[PW-2:0], 1'b0};
  assign a2_im_d = {a_im_al_q[PW-2:0], 1'b0};

  // Stage 3: the sum is rounded while the difference D = 2A - S is formed.
  logic [PW-1:0]         d_re_d, d_im_d, d_re_q, d_im_q;
  logic [DATA_WIDTH-1:0] sum_re_d, sum_im_d, sum3_re_q, sum3_im_q;

  assign d_re_d = a2_re_q - s_re_q;
  assign d_im_d = a2_im_q - s_im_q;

  r2bf_round #(.DATA_WIDTH(DATA_WIDTH)) u_round_s_re (
    .value_i (s_re_q),
    .result_o(sum_re_d)
  );

  r2bf_round #(.DATA_WIDTH(DATA_WIDTH)) u_round_s_im (
    .value_i (s_im_q),
    .result_o(sum_im_d)
  );

  // Stage 4: the difference is rounded; the rounded sum passes one more register so
  // that all four fields leave together.
  logic [DATA_WIDTH-1:0] diff_re_d, diff_im_d;
  logic [DATA_WIDTH-1:0] sum_re_q, sum_im_q, diff_re_q, diff_im_q;

  r2bf_round #(.DATA_WIDTH(DATA_WIDTH)) u_round_d_re (
    .value_i (d_re_q),
    .result_o(diff_re_d)
  );

  r2bf_round #(.DATA_WIDTH(DATA_WIDTH)) u_round_d_im (
    .value_i (d_im_q),
    .result_o(diff_im_d)
  );

  // Payload registers carry no reset; only the valid bits above matter.
  always_ff @(posedge clk_i) begin
    p_rr_q    <= p_rr_d;
    p_ii_q    <= p_ii_d;
    p_ri_q    <= p_ri_d;
    p_ir_q    <= p_ir_d;
    a_re_al_q <= a_re_al_d;
    a_im_al_q <= a_im_al_d;
    s_re_q    <= s_re_d;
    s_im_q    <= s_im_d;
    a2_re_q   <= a2_re_d;
    a2_im_q   <= a2_im_d;
    d_re_q    <= d_re_d;
    d_im_q    <= d_im_d;
    sum3_re_q <= sum_re_d;
    sum3_im_q <= sum_im_d;
    sum_re_q  <= sum3_re_q;
    sum_im_q  <= sum3_im_q;
    diff_re_q <= diff_re_d;
    diff_im_q <= diff_im_d;
  end

  // One strobe per beat, in the cycle after the last stage loads.
  assign done_o    = valid_q[r2bf_pkg::LATENCY-1];
  assign sum_re_o  = sum_re_q;
  assign sum_im_o  = sum_im_q;
  assign diff_re_o = diff_re_q;
  assign diff_im_o = diff_im_q;

  // Every accepted beat produces its strobe once it has passed every stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("accepted beat did not produce a result strobe");

  // No strobe appears without an accepted beat that has passed every stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 4))
    else $error("result strobe without a matching accepted beat");

  // A valid bit in the second stage must come from a beat held in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> $past(valid_q[0]))
    else $error("stage valid bit appeared without an upstream beat");

endmodule

// ===== bench/radix2_fft_butterfly_tb.sv =====
// ----------------------------------------------------------------------------
// radix2_fft_butterfly_tb
// Self-checking bench for the scaled radix-2 butterfly. A queue of operand
// beats (directed corners first, then random ones) feeds a clocked driver
// that idles at random between beats. A clocked monitor compares every
// result strobe, field by field, with a bit-accurate prediction of
// (A + B*W)/2 and (A - B*W)/2 that is rounded half to even and wrapped.
// ----------------------------------------------------------------------------
module radix2_fft_butterfly_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DW          = 20;
  localparam int unsigned RANDOM_BEATS = 500;
  // The limit sits many times above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic signed [DW-1:0] sample_t;
  typedef logic signed [63:0]   wide_t;

  // One operand beat plus the number of idle cycles the driver inserts first.
  typedef struct packed {
    sample_t     a_re;
    sample_t     a_im;
    sample_t     b_re;
    sample_t     b_im;
    sample_t     tw_re;
    sample_t     tw_im;
    int unsigned gap;
  } operands_t;

  // The four fields of one butterfly result.
  typedef struct packed {
    sample_t sum_re;
    sample_t sum_im;
    sample_t diff_re;
    sample_t diff_im;
  } butterfly_t;

  localparam sample_t S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam sample_t S_ONE = sample_t'(1);

  // Clock, reset and the ports of the block. Every input has a known value
  // from time zero.
  logic    clk_i;
  logic    rst_ni   = 1'b0;
  logic    start_i  = 1'b0;
  logic    busy_o;
  sample_t a_re_i   = '0;
  sample_t a_im_i   = '0;
  sample_t b_re_i   = '0;
  sample_t b_im_i   = '0;
  sample_t tw_re_i  = '0;
  sample_t tw_im_i  = '0;
  logic    done_o;
  sample_t sum_re_o;
  sample_t sum_im_o;
  sample_t diff_re_o;
  sample_t diff_im_o;

  // Beats still to be offered, and predicted butterflies still to arrive.
  operands_t   operand_queue[$];
  butterfly_t  butterfly_queue[$];

  int unsigned error_count  = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count  = 0;

  // Driver state: the beat being offered (or waiting out its idle cycles).
  operands_t   cur_beat;
  bit          have_beat = 1'b0;
  int unsigned idle_left = 0;
  bit          offer;

  // Idle pattern: runs of beats with random gaps alternate with runs that
  // are sent back to back, so gaps land on every pipeline stage.
  bit          gap_run_quiet = 1'b0;
  int unsigned gap_run_left  = 0;

  butterfly_t  want;

  radix2_fft_butterfly #(
    .DATA_WIDTH(DW)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .a_re_i   (a_re_i),
    .a_im_i   (a_im_i),
    .b_re_i   (b_re_i),
    .b_im_i   (b_im_i),
    .tw_re_i  (tw_re_i),
    .tw_im_i  (tw_im_i),
    .done_o   (done_o),
    .sum_re_o (sum_re_o),
    .sum_im_o (sum_im_o),
    .diff_re_o(diff_re_o),
    .diff_im_o(diff_im_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Sign-extend a field to 64 bits; every intermediate below fits easily.
  function automatic wide_t widen(sample_t v);
    return {{(64-DW){v[DW-1]}}, v};
  endfunction

  // Divide by 2^DW, round to nearest with ties to even, keep the low DW bits.
  // The half bit decides; on an exact half the kept LSB breaks the tie.
  function automatic sample_t scale_round(wide_t v);
    wide_t q;
    logic  up;
    q  = v >>> DW;
    up = v[DW-1] & (q[0] | (v[DW-2:0] != '0));
    q  = q + wide_t'(up);
    return q[DW-1:0];
  endfunction

  // Full-precision butterfly. A is aligned to the Q(DW-1) scale of the
  // products; the difference is formed as 2A minus the sum, as in hardware.
  function automatic butterfly_t butterfly_predict(operands_t x);
    wide_t      a_re_al;
    wide_t      a_im_al;
    wide_t      s_re;
    wide_t      s_im;
    butterfly_t r;
    a_re_al   = widen(x.a_re) <<< (DW - 1);
    a_im_al   = widen(x.a_im) <<< (DW - 1);
    s_re      = a_re_al + widen(x.b_re) * widen(x.tw_re) - widen(x.b_im) * widen(x.tw_im);
    s_im      = a_im_al + widen(x.b_re) * widen(x.tw_im) + widen(x.b_im) * widen(x.tw_re);
    r.sum_re  = scale_round(s_re);
    r.sum_im  = scale_round(s_im);
    r.diff_re = scale_round((a_re_al <<< 1) - s_re);
    r.diff_im = scale_round((a_im_al <<< 1) - s_im);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random field biased toward the corners: extremes, zero, minus one and
  // small magnitudes show up often, full-range values the rest of the time.
  function automatic sample_t rand_field();
    case ($urandom_range(0, 11))
      0: begin
        return S_MAX;
      end
      1: begin
        return S_MIN;
      end
      2: begin
        return '0;
      end
      3: begin
        return '1;
      end
      4: begin
        return sample_t'($urandom_range(0, 15));
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  task automatic queue_beat(sample_t ar, sample_t ai, sample_t br, sample_t bi,
                            sample_t wr, sample_t wi);
    operands_t b;
    if (gap_run_left == 0) begin
      gap_run_quiet = ($urandom_range(0, 2) == 0);
      gap_run_left  = $urandom_range(10, 40);
    end
    gap_run_left = gap_run_left - 1;
    b.a_re  = ar;
    b.a_im  = ai;
    b.b_re  = br;
    b.b_im  = bi;
    b.tw_re = wr;
    b.tw_im = wi;
    b.gap   = gap_run_quiet ? 0 : $urandom_range(0, 14);
    operand_queue.push_back(b);
  endtask

  // One line per mismatch, and a count for the verdict.
  task automatic flag_error(string msg);
    error_count = error_count + 1;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, sample_t got, sample_t exp_v);
    if (got !== exp_v) begin
      flag_error($sformatf("result %0d %s: got %0d, predicted %0d",
                           result_count, name, got, exp_v));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------------
  // A beat is taken at an edge where start_i is high and busy_o is low. The
  // prediction is pushed at that same edge from the beat still on the ports.
  // After that the next beat is pulled, its idle cycles are spent with
  // start_i low and junk on the operand ports, and then it is offered until
  // taken. start_i gets exactly one nonblocking assignment per edge.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        butterfly_queue.push_back(butterfly_predict(cur_beat));
        have_beat = 1'b0;
      end
      if (!have_beat && operand_queue.size() != 0) begin
        cur_beat  = operand_queue.pop_front();
        idle_left = cur_beat.gap;
        have_beat = 1'b1;
      end
      if (have_beat && idle_left != 0) begin
        idle_left = idle_left - 1;
        offer     = 1'b0;
      end else begin
        offer = have_beat;
      end
      start_i <= offer;
      if (offer) begin
        a_re_i  <= cur_beat.a_re;
        a_im_i  <= cur_beat.a_im;
        b_re_i  <= cur_beat.b_re;
        b_im_i  <= cur_beat.b_im;
        tw_re_i <= cur_beat.tw_re;
        tw_im_i <= cur_beat.tw_im;
      end else begin
        // The block must ignore whatever sits on the operands while idle.
        a_re_i  <= sample_t'($urandom);
        a_im_i  <= sample_t'($urandom);
        b_re_i  <= sample_t'($urandom);
        b_im_i  <= sample_t'($urandom);
        tw_re_i <= sample_t'($urandom);
        tw_im_i <= sample_t'($urandom);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------
  // done_o marks a result for one cycle; it is sampled at the edge that ends
  // that cycle, before the block's registers update in the same step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (butterfly_queue.size() == 0) begin
          flag_error($sformatf("result strobe with no butterfly pending (sum_re %0d)",
                               sum_re_o));
        end else begin
          want = butterfly_queue.pop_front();
          check_field("sum_re", sum_re_o, want.sum_re);
          check_field("sum_im", sum_im_o, want.sum_im);
          check_field("diff_re", diff_re_o, want.diff_re);
          check_field("diff_im", diff_im_o, want.diff_im);
        end
        result_count = result_count + 1;
      end else if (done_o !== 1'b0) begin
        flag_error("done_o is unknown");
      end
    end
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of test
  // ---------------------------------------------------------------------------
  initial begin
    // Directed corners. All zeros, then every field at its positive and
    // negative extreme, which drives the full-precision sums into wrap.
    queue_beat('0, '0, '0, '0, '0, '0);
    queue_beat(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX);
    queue_beat(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN);
    queue_beat(S_MAX, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN);
    queue_beat(S_MIN, S_MIN, S_MIN, S_MIN, S_MAX, S_MAX);
    queue_beat(S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, S_MIN);
    queue_beat('1, '1, '1, '1, '1, '1);
    // Zero twiddle leaves A/2: odd A lands exactly on a half, so these hit
    // the tie rule both ways, positive and negative.
    queue_beat(S_ONE, sample_t'(3), S_MAX, S_MIN, '0, '0);
    queue_beat('1, sample_t'(-3), S_MIN, S_MAX, '0, '0);
    queue_beat(S_MAX, S_MIN, '1, S_ONE, '0, '0);
    // A product that is exactly half an output step, added to even and odd A.
    queue_beat('0, S_ONE, sample_t'(2), '0, sample_t'(1 << (DW - 2)), '0);
    queue_beat(S_ONE, '0, sample_t'(2), '0, sample_t'(1 << (DW - 2)), '0);
    // Smallest nonzero product: just above zero, and just below for diff.
    queue_beat('0, '0, S_ONE, '0, S_ONE, '0);
    queue_beat('0, '0, S_ONE, S_ONE, S_MAX, S_MAX);
    // Twiddle of almost +1 and of almost +j.
    queue_beat(sample_t'(12345), sample_t'(-54321), sample_t'(77777),
               sample_t'(-33333), S_MAX, '0);
    queue_beat(sample_t'(-12345), sample_t'(54321), sample_t'(-77777),
               sample_t'(33333), '0, S_MAX);
    // Alternating bit patterns so every operand bit toggles early.
    queue_beat(sample_t'(20'h55555), sample_t'(20'hAAAAA), sample_t'(20'h55555),
               sample_t'(20'hAAAAA), sample_t'(20'h55555), sample_t'(20'hAAAAA));
    queue_beat(sample_t'(20'hAAAAA), sample_t'(20'h55555), sample_t'(20'hAAAAA),
               sample_t'(20'h55555), sample_t'(20'hAAAAA), sample_t'(20'h55555));

    // Random beats. About one in ten zeroes the twiddle so ties stay common.
    repeat (RANDOM_BEATS) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_beat(rand_field(), rand_field(), rand_field(), rand_field(), '0, '0);
      end else begin
        queue_beat(rand_field(), rand_field(), rand_field(), rand_field(),
                   rand_field(), rand_field());
      end
    end

    // Reset once at the start, released on a rising edge.
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every beat is taken and every prediction has been matched,
    // then give the pipeline its latency and a little margin to show any
    // stray strobe.
    while (operand_queue.size() != 0 || have_beat || start_i
           || butterfly_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (r2bf_pkg::LATENCY + 4) @(posedge clk_i);

    if (butterfly_queue.size() != 0) begin
      flag_error($sformatf("%0d butterflies never arrived", butterfly_queue.size()));
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
